FILE: hw/rtl/cls_pkg.sv
package cls_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int ENTRY_BITS_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int RIDX_W   = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_REPLACE = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_FIND    = 3'd3,
    OP_CLEAR   = 3'd4
  } cls_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } cls_status_t;

  typedef struct packed {
    logic take;
    logic append;
    logic replace;
    logic remove;
    logic find;
  } cls_cmd_t;

endpackage

FILE: hw/rtl/cls_cell.sv
module cls_cell #(
  parameter int ENTRY_BITS = 32,
  parameter int EXT_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cls_pkg::cls_cmd_t      cmd,
  input  logic [EXT_W-1:0]       pos,
  input  logic [EXT_W-1:0]       count,
  input  logic [ENTRY_BITS-1:0]  value,
  input  logic [ENTRY_BITS-1:0]  neighbor,
  output logic [ENTRY_BITS-1:0]  entry,
  output logic                   match
);
  import cls_pkg::*;

  localparam logic [EXT_W-1:0] K_SELF = EXT_W'(INDEX);
  localparam logic [EXT_W-1:0] K_NEXT = EXT_W'(INDEX + 1);

  logic occupied;
  logic load_new;
  logic shift;

  assign occupied = count > K_SELF;
  assign load_new = (cmd.append && count == K_SELF) ||
                    (cmd.replace && pos == K_SELF && occupied);
  assign shift    = cmd.remove && pos <= K_SELF && K_NEXT < count;

  always_ff @(posedge clk) begin
    if (load_new) begin
      entry <= value;
    end else if (shift) begin
      entry <= neighbor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (cmd.take) begin
      match <= cmd.find && occupied && entry == value;
    end
  end

endmodule

FILE: hw/rtl/cls_prio_enc.sv
module cls_prio_enc #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic [DEPTH-1:0] match,
  output logic [IDX_W-1:0] index,
  output logic             any
);
  import cls_pkg::*;

  logic [DEPTH-1:0] lowest;

  assign lowest = match & (~match + DEPTH'(1));
  assign any    = |match;

  always_comb begin
    index = '0;
    for (int b = 0; b < IDX_W; b++) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (((k >> b) & 1) == 1) begin
          index[b] = index[b] | lowest[k];
        end
      end
    end
  end

endmodule

FILE: hw/rtl/compacting_list_with_search_top.sv
// an accepted word passes through the s1 stage registers, then the result registers
// throughput: one word per cycle while the result side keeps up
// state changes at the accept edge; find compares in every cell, then a priority encode
// reset clears the entry count and all handshake state; cell contents are kept
// entries at or above the count are never read, so no clearing pass is needed
module compacting_list_with_search_top #(
  parameter int DEPTH      = cls_pkg::DEPTH_DEF,
  parameter int ENTRY_BITS = cls_pkg::ENTRY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [cls_pkg::MODE_W-1:0]    mode,
  input  logic [cls_pkg::POS_W-1:0]     position,
  input  logic [cls_pkg::VALUE_W-1:0]   entry_value,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [cls_pkg::RIDX_W-1:0]    result_index,
  output logic                          found,
  output logic [cls_pkg::STATUS_W-1:0]  status,
  output logic [cls_pkg::COUNT_W-1:0]   entry_count
);
  import cls_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [EXT_W-1:0] FULL_COUNT = EXT_W'(DEPTH);

  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [EXT_W-1:0]       count_x;
  logic [EXT_W-1:0]       pos_x;
  logic [ENTRY_BITS-1:0]  value_in;
  logic                   take;
  logic                   move;
  cls_op_t                op;
  cls_cmd_t               cmd;
  cls_status_t            st_next;
  logic [RIDX_W-1:0]      idx_next;

  logic                   s1_valid;
  cls_status_t            s1_status;
  logic [RIDX_W-1:0]      s1_index;
  logic [COUNT_W-1:0]     s1_count;

  cls_status_t            res_status;

  logic [ENTRY_BITS-1:0]  cell_entry [DEPTH];
  logic [DEPTH-1:0]       match;
  logic [IDX_W-1:0]       hit_index;
  logic                   hit_any;
  logic [EXT_W-1:0]       hit_index_x;

  assign count_x    = EXT_W'(count);
  assign pos_x      = EXT_W'(position);
  assign value_in   = ENTRY_BITS'(entry_value);
  assign op         = cls_op_t'(mode);
  assign item_stall = s1_valid && result_valid && result_stall;
  assign take       = item_valid && !item_stall;
  assign move       = s1_valid && (!result_valid || !result_stall);

  always_comb begin
    cmd        = '0;
    cmd.take   = take;
    count_next = count;
    st_next    = ST_OK;
    idx_next   = '0;
    case (op)
      OP_APPEND: begin
        if (count_x == FULL_COUNT) begin
          st_next = ST_FULL;
        end else begin
          cmd.append = take;
          idx_next   = count_x[RIDX_W-1:0];
          count_next = count + CNT_W'(1);
        end
      end
      OP_REPLACE: begin
        if (pos_x >= count_x) begin
          st_next = ST_RANGE;
        end else begin
          cmd.replace = take;
        end
      end
      OP_REMOVE: begin
        if (pos_x >= count_x) begin
          st_next = ST_RANGE;
        end else begin
          cmd.remove = take;
          count_next = count - CNT_W'(1);
        end
      end
      OP_FIND: begin
        cmd.find = take;
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ENTRY_BITS-1:0] neighbor;
    if (k < DEPTH - 1) begin : g_mid
      assign neighbor = cell_entry[k+1];
    end else begin : g_last
      assign neighbor = cell_entry[k];
    end
    cls_cell #(
      .ENTRY_BITS (ENTRY_BITS),
      .EXT_W      (EXT_W),
      .INDEX      (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .pos      (pos_x),
      .count    (count_x),
      .value    (value_in),
      .neighbor (neighbor),
      .entry    (cell_entry[k]),
      .match    (match[k])
    );
  end

  cls_prio_enc #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_prio_enc (
    .match (match),
    .index (hit_index),
    .any   (hit_any)
  );

  assign hit_index_x = EXT_W'(hit_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (take) begin
        count <= count_next;
      end
      if (take) begin
        s1_valid <= 1'b1;
      end else if (move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_status <= st_next;
      s1_index  <= idx_next;
      s1_count  <= COUNT_W'(EXT_W'(count_next));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      result_index <= hit_any ? hit_index_x[RIDX_W-1:0] : s1_index;
      found        <= hit_any;
      res_status   <= s1_status;
      entry_count  <= s1_count;
    end
  end

  assign status = res_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_x <= FULL_COUNT)
    else $error("entry count above depth");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    take && op == OP_APPEND && count_x == FULL_COUNT |=> $stable(count))
    else $error("append on a full list changed the count");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && found |-> res_status == ST_OK)
    else $error("match reported with an error status");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && result_valid)
    else $error("input stalled with a free pipeline");

  a_move_loads: assert property (@(posedge clk) disable iff (rst)
    move |=> result_valid)
    else $error("result not presented after stage handoff");

endmodule

FILE: tb/compacting_list_with_search_checker.sv
module compacting_list_with_search_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  logic [cls_pkg::MODE_W-1:0]    mode,
  input  logic [cls_pkg::POS_W-1:0]     position,
  input  logic [cls_pkg::VALUE_W-1:0]   entry_value,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic [cls_pkg::RIDX_W-1:0]    result_index,
  input  logic                          found,
  input  logic [cls_pkg::STATUS_W-1:0]  status,
  input  logic [cls_pkg::COUNT_W-1:0]   entry_count,
  output int                            outstanding,
  output int                            fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import cls_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [VALUE_W-1:0] VALUE_MASK = VALUE_W'((64'd1 << ENTRY_BITS_DEF) - 64'd1);

  typedef struct {
    logic [RIDX_W-1:0]   index;
    logic                hit;
    logic [STATUS_W-1:0] st;
    logic [COUNT_W-1:0]  cnt;
  } list_result_t;

  logic [VALUE_W-1:0] list_mem [DEPTH];
  int                 list_len;
  list_result_t       expected_results [$];

  initial begin
    fail_count = 0;
    outstanding = 0;
    list_len = 0;
    for (int i = 0; i < DEPTH; i++) list_mem[i] = '0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic apply_list_op(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
                               input logic [VALUE_W-1:0] v, output list_result_t r);
    logic [VALUE_W-1:0] val;
    int pos;
    val = v & VALUE_MASK;
    pos = int'(p);
    r.index = '0;
    r.hit = 1'b0;
    r.st = ST_OK;
    case (m)
      OP_APPEND: begin
        if (list_len >= DEPTH) begin
          r.st = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          r.index = RIDX_W'(list_len);
          list_len++;
        end
      end
      OP_REPLACE: begin
        if (pos >= list_len) r.st = ST_RANGE;
        else list_mem[pos] = val;
      end
      OP_REMOVE: begin
        if (pos >= list_len) begin
          r.st = ST_RANGE;
        end else begin
          for (int k = pos; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
          list_len--;
        end
      end
      OP_FIND: begin
        for (int k = 0; k < list_len; k++) begin
          if (!r.hit && list_mem[k] == val) begin
            r.index = RIDX_W'(k);
            r.hit = 1'b1;
          end
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    r.cnt = COUNT_W'(list_len);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    list_result_t pred;
    if (rst) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      // result word first: it belongs to an earlier input word
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word", 32'(entry_count), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (result_index !== want.index)
            report_mismatch("result_index", 32'(result_index), 32'(want.index));
          if (found !== want.hit)
            report_mismatch("found", 32'(found), 32'(want.hit));
          if (status !== want.st)
            report_mismatch("status", 32'(status), 32'(want.st));
          if (entry_count !== want.cnt)
            report_mismatch("entry_count", 32'(entry_count), 32'(want.cnt));
        end
      end
      if (item_valid && !item_stall) begin
        apply_list_op(mode, position, entry_value, pred);
        expected_results.push_back(pred);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

FILE: tb/tb_compacting_list_with_search_top.sv
module tb_compacting_list_with_search_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cls_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 400;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [MODE_W-1:0]   mode = '0;
  logic [POS_W-1:0]    position = '0;
  logic [VALUE_W-1:0]  entry_value = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [RIDX_W-1:0]   result_index;
  logic                found;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;
  int                  outstanding;
  int                  fail_count;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int cycles = 0;

  logic [VALUE_W-1:0] value_pool [8] = '{32'h0, 32'hffff_ffff, 32'h1, 32'h8000_0000,
                                          32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678,
                                          32'h7fff_ffff};

  always #1 clk = ~clk;

  compacting_list_with_search_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .mode         (mode),
    .position     (position),
    .entry_value  (entry_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_index (result_index),
    .found        (found),
    .status       (status),
    .entry_count  (entry_count)
  );

  compacting_list_with_search_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .mode         (mode),
    .position     (position),
    .entry_value  (entry_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_index (result_index),
    .found        (found),
    .status       (status),
    .entry_count  (entry_count),
    .outstanding  (outstanding),
    .fail_count   (fail_count)
  );

  // result side: random stall, or a long hold when asked
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        repeat (n) begin
          result_stall <= 1'b1;
          @(posedge clk);
        end
      end
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
                           input logic [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    mode <= m;
    position <= p;
    entry_value <= v;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic drain;
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 5) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic send_random_word;
    int r;
    logic [MODE_W-1:0] m;
    logic [POS_W-1:0] p;
    r = $urandom_range(0, 99);
    if (r < 36) m = OP_APPEND;
    else if (r < 52) m = OP_REPLACE;
    else if (r < 72) m = OP_REMOVE;
    else if (r < 95) m = OP_FIND;
    else if (r < 97) m = OP_CLEAR;
    else m = MODE_W'($urandom_range(5, 7));
    if ($urandom_range(0, 1) == 0) p = POS_W'($urandom_range(0, 7));
    else p = POS_W'($urandom);
    send_word(m, p, pick_value());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list corners
    send_word(OP_FIND, 4'd0, 32'h0);
    send_word(OP_REMOVE, 4'd0, 32'h0);
    send_word(OP_REPLACE, 4'd15, 32'hffff_ffff);
    send_word(MODE_W'(5), 4'd3, 32'h1);
    send_word(MODE_W'(6), 4'd9, 32'h2);
    send_word(MODE_W'(7), 4'd15, 32'hffff_ffff);
    // fill up, then one more append on a full list
    send_word(OP_APPEND, 4'd0, 32'h0);
    send_word(OP_APPEND, 4'd15, 32'hffff_ffff);
    for (int i = 2; i < 16; i++) send_word(OP_APPEND, 4'd0, (i == 9) ? 32'h0 : $urandom);
    send_word(OP_APPEND, 4'd0, 32'h1234_5678);
    send_word(OP_FIND, 4'd0, 32'hffff_ffff);
    send_word(OP_FIND, 4'd0, 32'h0);
    send_word(OP_REPLACE, 4'd15, 32'hdead_beef);
    send_word(OP_REMOVE, 4'd15, 32'h0);
    send_word(OP_REMOVE, 4'd0, 32'h0);
    send_word(OP_CLEAR, 4'd0, 32'h0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      repeat (PHASE_WORDS) send_random_word();
      drain();
      if (ph == 0) begin
        // long hold on the result side while words keep coming
        hold_req = 300;
        repeat (40) send_random_word();
        drain();
      end
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
